// ===== rtl/core/hcd_pkg.sv =====
// Shared types and constants for the HTTP chunked body decoder.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package hcd_pkg;

  typedef enum logic [1:0] {
    PH_LINE = 2'd0,
    PH_DATA = 2'd1,
    PH_DONE = 2'd2,
    PH_ERR  = 2'd3
  } phase_t;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_NUL  = 2'd2;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // one classified item, as handed from front to back
  typedef struct packed {
    logic [7:0] raw;
    logic       is_nul;
    logic       is_lf;
    logic       is_cr;
    logic       is_hex;
    logic [3:0] hex_val;
  } item_t;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hcd_front.sv =====
// Front end: takes raw bytes and classifies them into items for the queue.
// Depends on hcd_pkg.
`default_nettype none

module hcd_front (
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          q_full,
  output logic               q_push,
  output hcd_pkg::item_t     q_item
);

  logic [4:0] hex_dec;

  assign hex_dec  = hcd_pkg::hex_decode(in_byte);
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.raw     = in_byte;
    q_item.is_nul  = (in_byte == hcd_pkg::CHAR_NUL);
    q_item.is_lf   = (in_byte == hcd_pkg::CHAR_LF);
    q_item.is_cr   = (in_byte == hcd_pkg::CHAR_CR);
    q_item.is_hex  = hex_dec[4];
    q_item.hex_val = hex_dec[3:0];
  end

endmodule

`default_nettype wire

// ===== rtl/core/hcd_queue.sv =====
// Short FIFO of classified items between front and back.
// Depends on hcd_pkg (item_t, QUEUE_DEPTH).
`default_nettype none

module hcd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire hcd_pkg::item_t push_item,
  input  wire logic           pop,
  output logic                full,
  output logic                not_empty,
  output hcd_pkg::item_t      head
);

  localparam int Depth  = hcd_pkg::QUEUE_DEPTH;
  localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  hcd_pkg::item_t mem_r [Depth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CountW-1:0] count_r, count_nxt;

  assign full      = (count_r == CountW'(Depth));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue popped while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CountW'(Depth))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== rtl/core/hcd_back.sv =====
// Back end: line/data state machine, chunk counters and the output register.
// Depends on hcd_pkg (phase_t, item_t, kind codes).
`default_nettype none

module hcd_back #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_not_empty,
  input  wire hcd_pkg::item_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_data_byte,
  output logic [1:0]          out_kind
);

  hcd_pkg::phase_t phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] chunk_len_r, chunk_len_nxt;
  logic [LENGTH_BITS-1:0] passed_r, passed_nxt;
  logic [LENGTH_BITS-1:0] accum_r, accum_nxt;
  logic                   stopped_r, stopped_nxt;
  logic [1:0]             line_chars_r, line_chars_nxt;
  logic                   last_cr_r, last_cr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_data_r, out_data_nxt;
  logic [1:0]             out_kind_r, out_kind_nxt;
  logic                   slot_free;
  logic                   emit;
  logic [7:0]             emit_data;
  logic [1:0]             emit_kind;
  logic [LENGTH_BITS-1:0] passed_inc;
  logic                   empty_line;

  assign slot_free  = !out_valid_r || out_ready;
  assign q_pop      = q_not_empty && slot_free;
  assign passed_inc = passed_r + 1'b1;
  assign empty_line = (line_chars_r == 2'd0) || (line_chars_r == 2'd1 && last_cr_r);

  assign out_valid     = out_valid_r;
  assign out_data_byte = out_data_r;
  assign out_kind      = out_kind_r;

  always_comb begin
    phase_nxt      = phase_r;
    chunk_len_nxt  = chunk_len_r;
    passed_nxt     = passed_r;
    accum_nxt      = accum_r;
    stopped_nxt    = stopped_r;
    line_chars_nxt = line_chars_r;
    last_cr_nxt    = last_cr_r;
    emit           = 1'b0;
    emit_data      = 8'd0;
    emit_kind      = hcd_pkg::KIND_DATA;

    if (q_pop) begin
      case (phase_r)
        hcd_pkg::PH_DATA: begin
          passed_nxt = passed_inc;
          if (passed_inc >= chunk_len_r) begin
            phase_nxt = hcd_pkg::PH_LINE;
          end
          emit      = 1'b1;
          emit_data = q_head.raw;
        end
        hcd_pkg::PH_DONE: begin
          // trailers and anything else after the end marker are dropped
        end
        hcd_pkg::PH_ERR: begin
          emit      = 1'b1;
          emit_kind = hcd_pkg::KIND_NUL;
        end
        hcd_pkg::PH_LINE: begin
          if (q_head.is_nul) begin
            phase_nxt = hcd_pkg::PH_ERR;
            emit      = 1'b1;
            emit_kind = hcd_pkg::KIND_NUL;
          end else if (q_head.is_lf) begin
            passed_nxt     = '0;
            accum_nxt      = '0;
            stopped_nxt    = 1'b0;
            line_chars_nxt = 2'd0;
            last_cr_nxt    = 1'b0;
            if (empty_line) begin
              chunk_len_nxt = '0;
            end else begin
              chunk_len_nxt = accum_r;
              if (accum_r == '0) begin
                phase_nxt = hcd_pkg::PH_DONE;
                emit      = 1'b1;
                emit_kind = hcd_pkg::KIND_END;
              end else begin
                phase_nxt = hcd_pkg::PH_DATA;
              end
            end
          end else begin
            if (line_chars_r != 2'd3) begin
              line_chars_nxt = line_chars_r + 2'd1;
            end
            last_cr_nxt = q_head.is_cr;
            if (!stopped_r) begin
              if (q_head.is_hex) begin
                accum_nxt = {accum_r[LENGTH_BITS-5:0], q_head.hex_val};
              end else begin
                stopped_nxt = 1'b1;
              end
            end
          end
        end
        default: begin
          phase_nxt = hcd_pkg::PH_LINE;
        end
      endcase
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_kind_nxt  = out_kind_r;
    if (slot_free) begin
      out_valid_nxt = emit;
      out_data_nxt  = emit_data;
      out_kind_nxt  = emit_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= hcd_pkg::PH_LINE;
      chunk_len_r  <= '0;
      passed_r     <= '0;
      accum_r      <= '0;
      stopped_r    <= 1'b0;
      line_chars_r <= 2'd0;
      last_cr_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      chunk_len_r  <= chunk_len_nxt;
      passed_r     <= passed_nxt;
      accum_r      <= accum_nxt;
      stopped_r    <= stopped_nxt;
      line_chars_r <= line_chars_nxt;
      last_cr_r    <= last_cr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
  end

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == hcd_pkg::PH_ERR |=> phase_r == hcd_pkg::PH_ERR)
    else $error("error phase left without reset");
  a_data_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == hcd_pkg::PH_DATA |-> chunk_len_r != '0 && passed_r < chunk_len_r)
    else $error("data phase with exhausted chunk");
  a_ctrl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != hcd_pkg::KIND_DATA |-> out_data_r == 8'd0)
    else $error("marker item carries a data byte");
  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == hcd_pkg::PH_DONE && q_pop |=> !out_valid_r)
    else $error("item emitted after end marker");

endmodule

`default_nettype wire

// ===== rtl/core/http_chunked_decoder.sv =====
// HTTP chunked body decoder, one byte per item on each channel.
// Accepted bytes pass the queue, then the output register, to out_valid.
// Throughput: 1 byte per cycle, sustained while the output is taken; the
// two-entry front/back queue and the output register absorb stalls.
// Reset (rst_n low, synchronous) returns to line mode, clears the counters,
// empties the queue and drops any pending result. Depends on hcd_pkg.
`default_nettype none

module http_chunked_decoder #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_data_byte,
  output logic [1:0]      out_kind
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_not_empty;
  hcd_pkg::item_t q_in_item;
  hcd_pkg::item_t q_head;

  hcd_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in_item)
  );

  hcd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  hcd_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data_byte (out_data_byte),
    .out_kind      (out_kind)
  );

endmodule

`default_nettype wire

// ===== bench/tb_http_chunked_decoder.sv =====
// Self-checking bench for http_chunked_decoder: chunked bodies with random content and sizes,
// random sender gaps and receiver stalls, each result checked against a byte-level decoder model.
// Depends on hcd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_http_chunked_decoder;

  localparam int LB = 32;
  localparam int ITEM_TARGET = 1850;
  localparam int HOLD_AT = 1200;
  localparam int HOLD_LEN = 400;
  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } chunk_result_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_data_byte;
  logic [1:0] out_kind;

  int bytes_sent = 0;
  int chunks_sent = 0;
  int burst_left = 0;
  string ending;

  http_chunked_decoder #(.LENGTH_BITS(LB)) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data_byte(out_data_byte),
    .out_kind     (out_kind)
  );

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // Tracks the decoder state byte by byte and keeps the results still owed.
  class chunk_decode_sb;
    hcd_pkg::phase_t ph;
    logic [LB-1:0] chunk_len;
    logic [LB-1:0] passed;
    logic [LB-1:0] accum;
    bit            stopped;
    bit [1:0]      nchars;
    bit            cr_last;
    chunk_result_t due[$];
    int            errors;
    int            shown;
    int            n_data;
    int            n_end;
    int            n_nul;

    function new();
      ph = hcd_pkg::PH_LINE;
      chunk_len = '0;
      passed = '0;
      accum = '0;
      stopped = 0;
      nchars = 0;
      cr_last = 0;
    endfunction

    function void note_input(logic [7:0] b);
      int d;
      if (ph == hcd_pkg::PH_DATA) begin
        passed = passed + 1'b1;
        if (passed >= chunk_len) ph = hcd_pkg::PH_LINE;
        due.push_back('{data: b, kind: hcd_pkg::KIND_DATA});
      end else if (ph == hcd_pkg::PH_ERR) begin
        due.push_back('{data: 8'h00, kind: hcd_pkg::KIND_NUL});
      end else if (ph == hcd_pkg::PH_LINE) begin
        if (b == hcd_pkg::CHAR_NUL) begin
          ph = hcd_pkg::PH_ERR;
          due.push_back('{data: 8'h00, kind: hcd_pkg::KIND_NUL});
        end else if (b == hcd_pkg::CHAR_LF) begin
          // a bare LF or a lone CR counts as an empty line
          if (nchars == 0 || (nchars == 1 && cr_last)) begin
            chunk_len = '0;
          end else begin
            chunk_len = accum;
            if (accum == '0) begin
              ph = hcd_pkg::PH_DONE;
              due.push_back('{data: 8'h00, kind: hcd_pkg::KIND_END});
            end else begin
              ph = hcd_pkg::PH_DATA;
            end
          end
          passed = '0;
          accum = '0;
          stopped = 0;
          nchars = 0;
          cr_last = 0;
        end else begin
          if (nchars != 2'd3) nchars++;
          cr_last = (b == hcd_pkg::CHAR_CR);
          if (!stopped) begin
            d = hex_nibble(b);
            if (d >= 0) accum = {accum[LB-5:0], 4'(d)};
            else stopped = 1;
          end
        end
      end
    endfunction

    function void check_result(logic [7:0] data, logic [1:0] kind);
      chunk_result_t w;
      case (kind)
        hcd_pkg::KIND_DATA: n_data++;
        hcd_pkg::KIND_END:  n_end++;
        default:            n_nul++;
      endcase
      if (due.size() == 0) begin
        errors++;
        if (shown < 10) $display("unexpected result: data %h kind %0d", data, kind);
        shown++;
      end else begin
        w = due.pop_front();
        if (w.data !== data || w.kind !== kind) begin
          errors++;
          if (shown < 10)
            $display("mismatch: data exp %h got %h, kind exp %0d got %0d",
                     w.data, data, w.kind, kind);
          shown++;
        end
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  chunk_decode_sb sb = new();

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_byte(logic [7:0] b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b);
    bytes_sent++;
    burst_left--;
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // sender goes quiet until the decoder has handed back everything owed
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] hex_char(int n);
    if (n < 10) return 8'("0" + n);
    return ($urandom_range(0, 1) != 0) ? 8'("A" + n - 10) : 8'("a" + n - 10);
  endfunction

  // a byte that neither ends the line nor trips the NUL check, and no hex digit unless allow_hex
  function automatic logic [7:0] junk_byte(bit allow_hex);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == hcd_pkg::CHAR_LF || (!allow_hex && hex_nibble(c) >= 0));
    return c;
  endfunction

  task automatic send_chunk();
    int size;
    int r;
    size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
    if ($urandom_range(0, 11) == 0) begin
      // nine digits: the top one falls off the length register
      send_byte(hex_char($urandom_range(0, 15)));
      for (int i = 7; i >= 0; i--) send_byte(hex_char((size >> (4 * i)) & 15));
    end else begin
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) send_byte("0");
      if (size > 15) send_byte(hex_char(size >> 4));
      send_byte(hex_char(size & 15));
    end
    r = $urandom_range(0, 9);
    if (r >= 8) begin
      send_byte(junk_byte(0));
      repeat ($urandom_range(0, 5)) send_byte(junk_byte(1));
    end
    if (r < 6 || $urandom_range(0, 1) != 0) send_byte(hcd_pkg::CHAR_CR);
    send_byte(hcd_pkg::CHAR_LF);
    repeat (size) send_byte(8'($urandom_range(0, 255)));
    r = $urandom_range(0, 9);
    if (r != 8 && r != 7) send_str("\r\n");
    if (r == 7) send_byte(hcd_pkg::CHAR_LF);
    if (r == 9) begin
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(0, 1) != 0) send_byte(hcd_pkg::CHAR_CR);
        send_byte(hcd_pkg::CHAR_LF);
      end
    end
    chunks_sent++;
  endtask

  // the stream ends one of three ways; each is terminal until reset
  task automatic send_ending();
    case ($urandom_range(0, 2))
      0: begin
        ending = "zero-size chunk with trailers";
        send_byte("0");
        if ($urandom_range(0, 1) != 0) send_str(";last=1");
        send_str("\r\nX-Check: 1\r\n\r\n");
        repeat (12) send_byte(8'($urandom_range(0, 255)));
        send_byte(hcd_pkg::CHAR_NUL);
      end
      1: begin
        ending = "size line without hex digits";
        send_byte(junk_byte(0));
        repeat ($urandom_range(0, 3)) send_byte(junk_byte(1));
        send_str("\r\n");
        repeat (12) send_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        ending = "NUL in a size line";
        if ($urandom_range(0, 1) != 0) send_str("1f");
        send_byte(hcd_pkg::CHAR_NUL);
        repeat (20) send_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // empty lines, NUL as payload, extension, LF-only ends, size that wraps
    send_byte(hcd_pkg::CHAR_LF);
    send_str("\r\n");
    send_str("1\r\n");
    send_byte(hcd_pkg::CHAR_NUL);
    send_str("\r\n");
    send_str("2;x\n");
    send_byte(8'hFF);
    send_byte(hcd_pkg::CHAR_LF);
    send_str("100000001\n");
    send_byte(hcd_pkg::CHAR_CR);
    drain();
    while (bytes_sent < ITEM_TARGET) send_chunk();
    send_ending();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d bytes in %0d chunks, ending with %s", bytes_sent, chunks_sent, ending);
    $display("checked %0d payload, %0d end and %0d error results",
             sb.n_data, sb.n_end, sb.n_nul);
    if (sb.errors == 0) begin
      $display("tb_http_chunked_decoder: done, clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb_http_chunked_decoder: done, errors");
    end
    $finish;
  end

  // receiver: stall pattern drawn at random among three modes, plus one long hold-off
  initial begin
    int cyc;
    int hold;
    int mode;
    cyc = 0;
    hold = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.check_result(out_data_byte, out_kind);
      cyc++;
      if (cyc % 50 == 0) mode = $urandom_range(0, 2);
      if (cyc == HOLD_AT) hold = HOLD_LEN;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle);
        $display("tb_http_chunked_decoder: done, errors");
        $finish;
      end
    end
  end

endmodule
